// ===== rtl/enh_pkg.sv =====
// enh_pkg: shared types, constants and codes of the expression node hash block
// used by enh_front, enh_queue, enh_back and expression_node_hash
`timescale 1ns / 1ps

package enh_pkg;

    // stream and configuration widths
    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 136;
    localparam int CFG_IDX_W   = 8;
    localparam int CODE_W      = 8;

    // default for the per-node child limit
    localparam int MAX_CHILDREN_DEF = 255;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // hash mixing constants
    localparam logic [63:0] MUL_OPCODE = 64'h0113_1462_E270_012B;
    localparam logic [63:0] VAR_MIX    = 64'h03A8_3A83_A83A_83A0;
    localparam logic [63:0] CHILD_ADD  = 64'h0000_09AB_CD80_1357;
    localparam logic [63:0] CHILD_ADD3 = 64'(3 * CHILD_ADD);
    localparam logic [43:0] CHILD_MUL  = 44'hECA_DB91_2345;
    localparam logic [63:0] IMM_MIX    = 64'd1234567;
    localparam logic [63:0] CALL_MIX   = 64'd3456789;
    localparam logic [63:0] CHILD_MIX  = 64'd4567890;

    // biased exponent of zero, infinity and nan; normal and subnormal offsets
    localparam logic [15:0] EXP_ZERO   = 16'h8000;
    localparam logic [15:0] EXP_NORMAL = 16'h7C02;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMMEDIATE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIABLE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FUNC_CALL   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARSER_CALL = 8'd3;

    // node class picked by the front
    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_IMM   = 2'd1,
        CLS_VAR   = 2'd2,
        CLS_CALL  = 2'd3
    } t_class;

    // one classified item in the queue
    typedef struct packed {
        logic        kind;
        logic        last;
        t_class      cls;
        logic [7:0]  opcode;
        logic [63:0] node_value;
        logic [15:0] var_or_func;
        logic [63:0] child_key;
        logic [63:0] child_unique;
        logic [7:0]  child_depth;
    } t_entry;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] level;
    } t_queue_status;

    typedef struct packed {
        logic idle;
        logic node_open;
    } t_back_status;

endpackage

// ===== rtl/enh_queue.sv =====
// enh_queue: short register queue of classified words between front and back
// depends on enh_pkg
`timescale 1ns / 1ps

module enh_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  enh_pkg::t_entry        i_entry,
    input  logic                   i_pop,
    output enh_pkg::t_entry        o_entry,
    output enh_pkg::t_queue_status o_status
);

    enh_pkg::t_entry                   r_mem [enh_pkg::QUEUE_DEPTH];
    logic [enh_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [enh_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [enh_pkg::QCNT_W-1:0]        r_level;

    localparam logic [enh_pkg::QPTR_W-1:0] LAST_PTR = enh_pkg::QPTR_W'(enh_pkg::QUEUE_DEPTH - 1);
    localparam logic [enh_pkg::QCNT_W-1:0] FULL_LVL = enh_pkg::QCNT_W'(enh_pkg::QUEUE_DEPTH);

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (!i_push && i_pop) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    assign o_entry        = r_mem[r_rd_ptr];
    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level == FULL_LVL);
    assign o_status.level = r_level;

endmodule

// ===== rtl/enh_front.sv =====
// enh_front: input stream unpacking, opcode registers and node classification
// depends on enh_pkg; feeds enh_queue
`timescale 1ns / 1ps

module enh_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_tvalid,
    output logic                            o_tready,
    input  logic [enh_pkg::IN_TDATA_W-1:0]  i_tdata,
    input  logic                            i_tuser,
    input  logic                            i_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [enh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [enh_pkg::CODE_W-1:0]      i_cfg_data,
    input  enh_pkg::t_queue_status          i_q_status,
    output logic                            o_push,
    output enh_pkg::t_entry                 o_entry
);

    logic [enh_pkg::CODE_W-1:0] r_imm_code;
    logic [enh_pkg::CODE_W-1:0] r_var_code;
    logic [enh_pkg::CODE_W-1:0] r_func_code;
    logic [enh_pkg::CODE_W-1:0] r_parser_code;
    logic [7:0]                 w_opcode;
    enh_pkg::t_class            w_cls;

    // opcode registers, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imm_code    <= 8'd0;
            r_var_code    <= 8'd1;
            r_func_code   <= 8'd2;
            r_parser_code <= 8'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                enh_pkg::CFG_IMMEDIATE:   r_imm_code    <= i_cfg_data;
                enh_pkg::CFG_VARIABLE:    r_var_code    <= i_cfg_data;
                enh_pkg::CFG_FUNC_CALL:   r_func_code   <= i_cfg_data;
                enh_pkg::CFG_PARSER_CALL: r_parser_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // classify, immediate over variable over the call codes
    assign w_opcode = i_tdata[7:0];
    always_comb begin
        if (w_opcode == r_imm_code) begin
            w_cls = enh_pkg::CLS_IMM;
        end else if (w_opcode == r_var_code) begin
            w_cls = enh_pkg::CLS_VAR;
        end else if (w_opcode == r_func_code || w_opcode == r_parser_code) begin
            w_cls = enh_pkg::CLS_CALL;
        end else begin
            w_cls = enh_pkg::CLS_OTHER;
        end
    end

    // unpack the word into a queue entry
    assign o_entry.kind         = i_tuser;
    assign o_entry.last         = i_tlast;
    assign o_entry.cls          = w_cls;
    assign o_entry.opcode       = w_opcode;
    assign o_entry.node_value   = i_tdata[71:8];
    assign o_entry.var_or_func  = i_tdata[87:72];
    assign o_entry.child_key    = i_tdata[151:88];
    assign o_entry.child_unique = i_tdata[215:152];
    assign o_entry.child_depth  = i_tdata[223:216];

    assign o_tready = !i_q_status.full;
    assign o_push   = i_tvalid && !i_q_status.full;

endmodule

// ===== rtl/enh_back.sv =====
// enh_back: sequencer that folds queued words into the node hash and holds
// the output register; depends on enh_pkg
`timescale 1ns / 1ps

module enh_back #(
    parameter int MAX_CHILDREN = enh_pkg::MAX_CHILDREN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  enh_pkg::t_entry                 i_entry,
    input  logic                            i_entry_valid,
    output logic                            o_pop,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [enh_pkg::OUT_TDATA_W-1:0] o_tdata,
    output enh_pkg::t_back_status           o_status
);

    localparam int IW = $clog2(MAX_CHILDREN + 1);
    localparam logic [IW-1:0] IDX_MAX = IW'(MAX_CHILDREN);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_NORM,
        S_IMM_KEY,
        S_IMM_MIX,
        S_IMM_ADD,
        S_CHILD_MUL,
        S_FINISH
    } t_state;

    t_state          r_state;
    logic [2:0]      r_step;
    logic [63:0]     r_acc_k;
    logic [63:0]     r_acc_u;
    logic [7:0]      r_max_d;
    logic [IW-1:0]   r_idx;
    logic            r_open;
    logic            r_takes;
    logic            r_last;
    enh_pkg::t_class r_cls;
    logic [63:0]     r_value;
    logic [15:0]     r_var;
    logic [63:0]     r_tmp;
    logic [63:0]     r_kprod;
    logic [51:0]     r_norm;
    logic [5:0]      r_shift;
    logic            r_out_valid;
    logic [63:0]     r_out_key;
    logic [63:0]     r_out_unique;
    logic [7:0]      r_out_depth;

    logic        w_take_child;
    logic [51:0] w_norm_next;
    logic [5:0]  w_shift_next;
    logic [15:0] w_chunk;
    logic [59:0] w_pp;
    logic [63:0] w_pp_shifted;
    logic        w_neg;
    logic [15:0] w_e16;
    logic [30:0] w_frac;
    logic [63:0] w_key;
    logic [63:0] w_crc;
    logic [63:0] w_nv;
    logic        w_out_free;

    assign o_pop        = (r_state == S_IDLE) && i_entry_valid;
    assign w_take_child = r_takes && (r_idx < IDX_MAX);
    assign w_out_free   = !r_out_valid || i_tready;

    // one binary normalization step of a subnormal mantissa
    always_comb begin
        w_norm_next  = r_norm;
        w_shift_next = r_shift;
        case (r_step)
            3'd0: if (r_norm[51:20] == '0) begin
                w_norm_next  = r_norm << 32;
                w_shift_next = r_shift + 6'd32;
            end
            3'd1: if (r_norm[51:36] == '0) begin
                w_norm_next  = r_norm << 16;
                w_shift_next = r_shift + 6'd16;
            end
            3'd2: if (r_norm[51:44] == '0) begin
                w_norm_next  = r_norm << 8;
                w_shift_next = r_shift + 6'd8;
            end
            3'd3: if (r_norm[51:48] == '0) begin
                w_norm_next  = r_norm << 4;
                w_shift_next = r_shift + 6'd4;
            end
            3'd4: if (r_norm[51:50] == '0) begin
                w_norm_next  = r_norm << 2;
                w_shift_next = r_shift + 6'd2;
            end
            3'd5: if (!r_norm[51]) begin
                w_norm_next  = r_norm << 1;
                w_shift_next = r_shift + 6'd1;
            end
            default: ;
        endcase
    end

    // immediate key from exponent class and normalized mantissa
    always_comb begin
        w_neg  = 1'b0;
        w_e16  = enh_pkg::EXP_ZERO;
        w_frac = '0;
        if (r_value[62:52] == 11'h7FF) begin
            w_neg = (r_value[51:0] == '0) && r_value[63];
        end else if (r_value[62:52] != '0) begin
            w_e16  = {5'b0, r_value[62:52]} + enh_pkg::EXP_NORMAL;
            w_frac = r_value[51:21];
            w_neg  = r_value[63];
        end else if (r_value[51:0] != '0) begin
            w_e16  = enh_pkg::EXP_NORMAL - {10'b0, r_shift};
            w_frac = r_norm[50:20];
            w_neg  = r_value[63];
        end
        w_key = {8'b0, !w_neg, (w_neg ? ~w_e16 : w_e16), w_frac, 8'b0};
    end

    // rotate right by ten for the unique mix
    assign w_crc = {r_acc_k[9:0], r_acc_k[63:10]};
    assign w_nv  = ~64'(r_var);

    // one 16-bit slice of the child multiply per cycle
    always_comb begin
        case (r_step[1:0])
            2'd0:    w_chunk = r_tmp[15:0];
            2'd1:    w_chunk = r_tmp[31:16];
            2'd2:    w_chunk = r_tmp[47:32];
            default: w_chunk = r_tmp[63:48];
        endcase
        w_pp = w_chunk * enh_pkg::CHILD_MUL;
        case (r_step[1:0])
            2'd0:    w_pp_shifted = 64'(w_pp);
            2'd1:    w_pp_shifted = {w_pp[47:0], 16'b0};
            2'd2:    w_pp_shifted = {w_pp[31:0], 32'b0};
            default: w_pp_shifted = {w_pp[15:0], 48'b0};
        endcase
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_acc_k     <= '0;
            r_acc_u     <= '0;
            r_max_d     <= '0;
            r_idx       <= '0;
            r_open      <= 1'b0;
            r_takes     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drain a taken result unless a new one loads this cycle
            if (r_out_valid && i_tready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_entry_valid) begin
                        r_last <= i_entry.last;
                        if (!i_entry.kind) begin
                            // begin word: restart the node
                            r_acc_k <= {i_entry.opcode, 56'b0};
                            r_acc_u <= 64'(i_entry.opcode) * enh_pkg::MUL_OPCODE;
                            r_max_d <= '0;
                            r_idx   <= '0;
                            r_open  <= 1'b1;
                            r_takes <= (i_entry.cls == enh_pkg::CLS_CALL) ||
                                       (i_entry.cls == enh_pkg::CLS_OTHER);
                            r_cls   <= i_entry.cls;
                            r_value <= i_entry.node_value;
                            r_var   <= i_entry.var_or_func;
                            r_norm  <= i_entry.node_value[51:0];
                            r_shift <= '0;
                            r_step  <= '0;
                            unique case (i_entry.cls)
                                enh_pkg::CLS_IMM: r_state <= S_NORM;
                                enh_pkg::CLS_VAR,
                                enh_pkg::CLS_CALL: r_state <= S_CLASS;
                                default: r_state <= i_entry.last ? S_FINISH : S_IDLE;
                            endcase
                        end else if (r_open) begin
                            if (w_take_child) begin
                                // child word: first half of the fold
                                if (i_entry.child_depth > r_max_d) begin
                                    r_max_d <= i_entry.child_depth;
                                end
                                r_kprod <= i_entry.child_key * 64'(r_idx + IW'(1));
                                r_tmp   <= r_acc_u + i_entry.child_key + enh_pkg::CHILD_ADD3;
                                r_acc_u <= (~i_entry.child_unique) ^ enh_pkg::CHILD_MIX;
                                r_idx   <= r_idx + IW'(1);
                                r_step  <= '0;
                                r_state <= S_CHILD_MUL;
                            end else if (i_entry.last) begin
                                r_state <= S_FINISH;
                            end
                        end
                    end
                end
                S_CLASS: begin
                    r_acc_k <= r_acc_k | {r_var, 48'b0};
                    if (r_cls == enh_pkg::CLS_VAR) begin
                        r_acc_u <= r_acc_u + ((64'(r_var) * 64'd11) ^ enh_pkg::VAR_MIX);
                    end else begin
                        r_acc_u <= r_acc_u + ((w_nv * 64'd7) ^ enh_pkg::CALL_MIX);
                    end
                    r_state <= r_last ? S_FINISH : S_IDLE;
                end
                S_NORM: begin
                    r_norm  <= w_norm_next;
                    r_shift <= w_shift_next;
                    r_step  <= r_step + 3'd1;
                    if (r_step == 3'd5) begin
                        r_state <= S_IMM_KEY;
                    end
                end
                S_IMM_KEY: begin
                    r_acc_k <= w_key;
                    r_state <= S_IMM_MIX;
                end
                S_IMM_MIX: begin
                    r_tmp   <= ((~w_crc) + ((~w_crc) << 1)) ^ enh_pkg::IMM_MIX;
                    r_state <= S_IMM_ADD;
                end
                S_IMM_ADD: begin
                    r_acc_u <= r_acc_u + r_tmp;
                    r_state <= r_last ? S_FINISH : S_IDLE;
                end
                S_CHILD_MUL: begin
                    r_acc_u <= r_acc_u + w_pp_shifted;
                    if (r_step == 3'd0) begin
                        r_acc_k <= r_acc_k + (r_kprod >> 12);
                    end
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd3) begin
                        r_state <= r_last ? S_FINISH : S_IDLE;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_key    <= r_acc_k;
                        r_out_unique <= r_acc_u;
                        r_out_depth  <= (r_max_d == 8'hFF) ? 8'hFF : r_max_d + 8'd1;
                        r_open       <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_tvalid           = r_out_valid;
    assign o_tdata            = {r_out_depth, r_out_unique, r_out_key};
    assign o_status.idle      = (r_state == S_IDLE);
    assign o_status.node_open = r_open;

endmodule

// ===== rtl/expression_node_hash.sv =====
// flow: the 4-entry queue takes one word per cycle while not full; the back end pops
//   a word only in S_IDLE, which handles a plain begin; a variable or call goes on to
//   S_CLASS, an immediate to S_NORM (six-step mantissa normalization) and the S_IMM
//   states, a child to S_CHILD_MUL (four-slice multiply); S_FINISH emits each result
// reset: synchronous active-low i_rst_n clears queue, node state and output valid,
//   and loads the opcode registers with 0, 1, 2, 3
`timescale 1ns / 1ps

module expression_node_hash #(
    parameter int MAX_CHILDREN = enh_pkg::MAX_CHILDREN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // opcode, node_value, var_or_func, child_key, child_unique, child_depth
    input  logic [enh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // hash_key, hash_unique, node_depth
    output logic [enh_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [enh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [enh_pkg::CODE_W-1:0]      i_cfg_data
);

    enh_pkg::t_queue_status w_q_status;
    enh_pkg::t_back_status  w_back_status;
    enh_pkg::t_entry        w_push_entry;
    enh_pkg::t_entry        w_pop_entry;
    logic                   w_push;
    logic                   w_pop;

    // accept and classify
    enh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_tlast     (s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    // decoupling queue
    enh_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_entry  (w_pop_entry),
        .o_status (w_q_status)
    );

    // hash fold and output register
    enh_back #(
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_pop_entry),
        .i_entry_valid (!w_q_status.empty),
        .o_pop         (w_pop),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_tdata       (m_axis_tdata),
        .o_status      (w_back_status)
    );

    // a result never shows a zero depth
    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[135:128] != 8'd0))
        else $error("node depth zero on output");

    // queue level stays within its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.level <= enh_pkg::QCNT_W'(enh_pkg::QUEUE_DEPTH))
        else $error("queue level beyond depth");

    // nothing in flight means no new result next cycle
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_status.empty && w_back_status.idle) |=> !$rose(m_axis_tvalid))
        else $error("result without a queued word");

    // emitting a result closes the node
    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !w_back_status.node_open)
        else $error("node still open after result");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for expression_node_hash, begin and child words in, node hashes out
// keeps its own model of the hash fold and compares every result word field by field
// depends on enh_pkg and the expression_node_hash top level
`timescale 1ns / 1ps

module tb;

    // word kinds carried on tuser
    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_CHILD = 1'b1;

    // hash mixing constants and the per-node child limit
    localparam logic [63:0] OPCODE_MULT  = 64'h0113_1462_E270_012B;
    localparam logic [63:0] VAR_SALT     = 64'h03A8_3A83_A83A_83A0;
    localparam logic [63:0] CHILD_OFFSET = 64'h0000_09AB_CD80_1357;
    localparam logic [63:0] CHILD_MULT   = 64'h0000_0ECA_DB91_2345;
    localparam logic [63:0] IMM_SALT     = 64'd1234567;
    localparam logic [63:0] CALL_SALT    = 64'd3456789;
    localparam logic [63:0] CHILD_SALT   = 64'd4567890;
    localparam int          CHILD_LIMIT  = 255;

    // cycles the back end may still be busy after the last result
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic        kind;
        logic        last;
        logic [7:0]  opcode;
        logic [63:0] node_value;
        logic [15:0] var_or_func;
        logic [63:0] child_key;
        logic [63:0] child_unique;
        logic [7:0]  child_depth;
    } t_hash_word;

    typedef struct {
        logic [63:0] key;
        logic [63:0] unique_val;
        logic [7:0]  depth;
    } t_node_hash;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [enh_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [enh_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            i_cfg_valid   = 1'b0;
    logic                            o_cfg_ready;
    logic [enh_pkg::CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [enh_pkg::CODE_W-1:0]      i_cfg_data    = '0;

    // opcode registers as the model sees them
    logic [7:0] imm_code    = 8'd0;
    logic [7:0] var_code    = 8'd1;
    logic [7:0] func_code   = 8'd2;
    logic [7:0] parser_code = 8'd3;

    // node accumulation state
    logic [63:0] acc_key        = '0;
    logic [63:0] acc_unique     = '0;
    logic [7:0]  deepest_child  = '0;
    int          child_count    = 0;
    bit          node_open      = 1'b0;
    bit          takes_children = 1'b0;

    t_node_hash expected_hashes[$];
    int         mismatch_count = 0;
    int         results_seen   = 0;
    int         results_paced  = 0;
    int         sink_stall     = 0;
    int         words_sent     = 0;
    bit         no_idle        = 1'b0;

    expression_node_hash dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // wait drawn for each word on either side, with idle-free stretches
    function automatic int pick_gap();
        if (no_idle) return 0;
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    // sort key of an immediate: biased exponent, sign flip, top fraction bits
    function automatic logic [63:0] immediate_key(input logic [63:0] bits);
        logic [10:0] bexp;
        logic [51:0] mant;
        logic [51:0] norm;
        logic [15:0] exp_biased;
        logic [30:0] frac;
        logic        neg;
        logic [63:0] key;
        int          msb;
        bexp       = bits[62:52];
        mant       = bits[51:0];
        exp_biased = 16'h8000;
        frac       = '0;
        neg        = 1'b0;
        if (bexp == 11'h7FF) begin
            // infinity or nan: only negative infinity is negative
            neg = (mant == '0) && bits[63];
        end else if (bexp != '0) begin
            exp_biased = 16'(int'(bexp) - 1022 + 32768);
            frac       = mant[51:21];
            neg        = bits[63];
        end else if (mant != '0) begin
            // subnormal: normalize so the leading one drops out
            msb = 51;
            while (!mant[msb]) msb--;
            exp_biased = 16'(msb - 1073 + 32768);
            norm       = mant << (52 - msb);
            frac       = norm[51:21];
            neg        = bits[63];
        end
        key = {48'b0, exp_biased};
        if (neg) key = key ^ 64'hFFFF;
        else     key = key + 64'h1_0000;
        return (key << 39) | ({33'b0, frac} << 8);
    endfunction

    // fold one accepted word into the node state, returns 1 when a hash is due
    function automatic bit fold_node_word(input t_hash_word w, output t_node_hash res);
        logic [63:0] vf;
        logic [63:0] ikey;
        logic [63:0] rot;
        logic [63:0] prod;
        vf  = 64'(w.var_or_func);
        res = '{default: '0};
        if (w.kind == KIND_BEGIN) begin
            acc_key        = 64'(w.opcode) << 56;
            acc_unique     = 64'(w.opcode) * OPCODE_MULT;
            deepest_child  = '0;
            child_count    = 0;
            node_open      = 1'b1;
            takes_children = 1'b1;
            if (w.opcode == imm_code) begin
                ikey           = immediate_key(w.node_value);
                rot            = {ikey[9:0], ikey[63:10]};
                acc_key        = ikey;
                acc_unique     = acc_unique + (((~rot) * 64'd3) ^ IMM_SALT);
                takes_children = 1'b0;
            end else if (w.opcode == var_code) begin
                acc_key        = acc_key | (vf << 48);
                acc_unique     = acc_unique + ((vf * 64'd11) ^ VAR_SALT);
                takes_children = 1'b0;
            end else if (w.opcode == func_code || w.opcode == parser_code) begin
                acc_key    = acc_key | (vf << 48);
                acc_unique = acc_unique + (((~vf) * 64'd7) ^ CALL_SALT);
            end
        end else begin
            // child with no node open is dropped, last included
            if (!node_open) return 1'b0;
            if (takes_children && child_count < CHILD_LIMIT) begin
                if (w.child_depth > deepest_child) deepest_child = w.child_depth;
                prod       = w.child_key * 64'(child_count + 1);
                acc_key    = acc_key + (prod >> 12);
                acc_unique = (acc_unique + w.child_key + 64'd3 * CHILD_OFFSET) * CHILD_MULT;
                acc_unique = acc_unique + ((~w.child_unique) ^ CHILD_SALT);
                child_count++;
            end
        end
        if (!w.last) return 1'b0;
        res.key        = acc_key;
        res.unique_val = acc_unique;
        res.depth      = (deepest_child == 8'hFF) ? 8'hFF : deepest_child + 8'd1;
        node_open      = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_hash_word begin_word(input logic [7:0] op, input logic [63:0] value,
                                              input logic [15:0] vf, input logic last);
        t_hash_word w;
        w.kind         = KIND_BEGIN;
        w.last         = last;
        w.opcode       = op;
        w.node_value   = value;
        w.var_or_func  = vf;
        w.child_key    = rand64();
        w.child_unique = rand64();
        w.child_depth  = 8'($urandom());
        return w;
    endfunction

    function automatic t_hash_word child_word(input logic [63:0] ck, input logic [63:0] cu,
                                              input logic [7:0] cd, input logic last);
        t_hash_word w;
        w.kind         = KIND_CHILD;
        w.last         = last;
        w.opcode       = 8'($urandom());
        w.node_value   = rand64();
        w.var_or_func  = 16'($urandom());
        w.child_key    = ck;
        w.child_unique = cu;
        w.child_depth  = cd;
        return w;
    endfunction

    // drive one word at the falling edge and hold it until accepted
    task automatic send_word(input t_hash_word w);
        t_node_hash res;
        int         gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.child_depth, w.child_unique, w.child_key,
                          w.var_or_func, w.node_value, w.opcode};
        s_axis_tuser  <= w.kind;
        s_axis_tlast  <= w.last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (fold_node_word(w, res)) expected_hashes.push_back(res);
        words_sent++;
        @(negedge i_clk);
    endtask

    // stop the stream and let every pending hash and queued word drain
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (expected_hashes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // write all four opcode registers, block idle
    task automatic load_codes(input logic [7:0] imm, input logic [7:0] vr,
                              input logic [7:0] fn, input logic [7:0] pc);
        logic [7:0]                    values[4];
        logic [enh_pkg::CFG_IDX_W-1:0] idx[4];
        values = '{imm, vr, fn, pc};
        idx    = '{enh_pkg::CFG_IMMEDIATE, enh_pkg::CFG_VARIABLE,
                   enh_pkg::CFG_FUNC_CALL, enh_pkg::CFG_PARSER_CALL};
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= values[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[i])
                enh_pkg::CFG_IMMEDIATE:   imm_code    = values[i];
                enh_pkg::CFG_VARIABLE:    var_code    = values[i];
                enh_pkg::CFG_FUNC_CALL:   func_code   = values[i];
                enh_pkg::CFG_PARSER_CALL: parser_code = values[i];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 9))
            0, 1:    return imm_code;
            2:       return var_code;
            3, 4:    return func_code;
            5, 6:    return parser_code;
            default: return 8'($urandom());
        endcase
    endfunction

    // double bits spread over zero, infinity, nan, subnormal and normal values
    function automatic logic [63:0] pick_double();
        logic [63:0] bits;
        bits = rand64();
        case ($urandom_range(0, 7))
            0: bits[62:0] = '0;
            1: bits[62:0] = {11'h7FF, 52'b0};
            2: begin
                bits[62:52] = 11'h7FF;
                if (bits[51:0] == '0) bits[0] = 1'b1;
            end
            3: begin
                bits[62:52] = '0;
                bits[51:0]  = bits[51:0] >> $urandom_range(0, 51);
                if (bits[51:0] == '0) bits[0] = 1'b1;
            end
            default: ;
        endcase
        return bits;
    endfunction

    function automatic logic [7:0] pick_depth();
        case ($urandom_range(0, 7))
            0:       return 8'hFF;
            1:       return 8'hFE;
            2:       return 8'h00;
            default: return 8'($urandom());
        endcase
    endfunction

    task automatic test_leaf_nodes();
        send_word(begin_word(8'd7, rand64(), 16'h1234, 1'b1));
        send_word(begin_word(var_code, rand64(), 16'hFFFF, 1'b1));
        send_word(begin_word(var_code, rand64(), 16'h0000, 1'b1));
        send_word(begin_word(func_code, rand64(), 16'h0000, 1'b1));
        send_word(begin_word(parser_code, rand64(), 16'hFFFF, 1'b1));
        send_word(begin_word(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1));
    endtask

    task automatic test_immediate_values();
        logic [63:0] vals[12];
        vals = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                 64'h7FF8_0000_0000_0000, 64'hFFF8_0000_0000_0001,
                 64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
                 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
                 64'h7FEF_FFFF_FFFF_FFFF, 64'h8010_0000_0000_0000};
        foreach (vals[i]) send_word(begin_word(imm_code, vals[i], 16'($urandom()), 1'b1));
    endtask

    task automatic test_child_folding();
        // call node with extreme children, depth saturates
        send_word(begin_word(func_code, rand64(), 16'hFFFF, 1'b0));
        send_word(child_word(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'd0, 1'b0));
        send_word(child_word(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b0));
        send_word(child_word(rand64(), rand64(), 8'd3, 1'b1));
        // plain opcode with one child
        send_word(begin_word(8'd40, rand64(), 16'h0, 1'b0));
        send_word(child_word(rand64(), rand64(), 8'd17, 1'b1));
        // children of immediate and variable nodes are ignored, last still ends them
        send_word(begin_word(imm_code, 64'h4009_21FB_5444_2D18, 16'h0, 1'b0));
        send_word(child_word(rand64(), rand64(), 8'd9, 1'b1));
        send_word(begin_word(var_code, rand64(), 16'h00AB, 1'b0));
        send_word(child_word(rand64(), rand64(), 8'd5, 1'b1));
    endtask

    task automatic test_stream_quirks();
        // child with no node open
        send_word(child_word(rand64(), rand64(), 8'd4, 1'b1));
        send_word(child_word(rand64(), rand64(), 8'd4, 1'b0));
        // node abandoned by a fresh begin
        send_word(begin_word(parser_code, rand64(), 16'h5555, 1'b0));
        send_word(child_word(rand64(), rand64(), 8'd200, 1'b0));
        send_word(begin_word(func_code, rand64(), 16'hAAAA, 1'b0));
        send_word(child_word(rand64(), rand64(), 8'd1, 1'b1));
    endtask

    task automatic test_child_limit();
        // children past the limit are dropped but the final last still closes
        send_word(begin_word(parser_code, rand64(), 16'h0F0F, 1'b0));
        for (int i = 0; i < CHILD_LIMIT + 2; i++)
            send_word(child_word(rand64(), rand64(), (i == CHILD_LIMIT + 1) ? 8'hFF : pick_depth(),
                                 i == CHILD_LIMIT + 1));
    endtask

    task automatic test_overlapping_codes();
        // immediate wins over all
        drain_block();
        load_codes(8'd9, 8'd9, 8'd9, 8'd9);
        send_word(begin_word(8'd9, 64'h3FF8_0000_0000_0000, 16'h0102, 1'b0));
        send_word(child_word(rand64(), rand64(), 8'd7, 1'b1));
        // variable wins over the call codes
        drain_block();
        load_codes(8'd200, 8'd77, 8'd77, 8'd77);
        send_word(begin_word(8'd77, rand64(), 16'hBEEF, 1'b0));
        send_word(child_word(rand64(), rand64(), 8'd7, 1'b1));
    endtask

    // one random node, sometimes noise or a broken node
    task automatic random_node();
        int n;
        case ($urandom_range(0, 19))
            0: send_word(child_word(rand64(), rand64(), pick_depth(), 1'($urandom())));
            1: begin
                send_word(begin_word(pick_opcode(), pick_double(), 16'($urandom()), 1'b0));
                n = $urandom_range(0, 3);
                repeat (n) send_word(child_word(rand64(), rand64(), pick_depth(), 1'b0));
            end
            default: begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
                send_word(begin_word(pick_opcode(), pick_double(), 16'($urandom()), n == 0));
                for (int i = 0; i < n; i++)
                    send_word(child_word(rand64(), rand64(), pick_depth(), i == n - 1));
            end
        endcase
    endtask

    task automatic test_random_nodes();
        logic [7:0] codes[5][4];
        int         stop_at;
        codes = '{'{8'd0, 8'd1, 8'd2, 8'd3},
                  '{8'd255, 8'd0, 8'd254, 8'd1},
                  '{8'd0, 8'd255, 8'd128, 8'd128},
                  '{8'd50, 8'd50, 8'd51, 8'd52},
                  '{8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom())}};
        for (int p = 0; p < 5; p++) begin
            drain_block();
            load_codes(codes[p][0], codes[p][1], codes[p][2], codes[p][3]);
            stop_at = words_sent + 90;
            while (words_sent < stop_at) begin
                if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
                random_node();
            end
            no_idle = 1'b0;
        end
    endtask

    // result pacing: stall drawn after each result word
    always @(negedge i_clk) begin
        if (results_seen != results_paced) begin
            results_paced = results_seen;
            sink_stall    = pick_gap();
        end
        if (sink_stall > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare every result word with the oldest expected hash
    always @(posedge i_clk) begin
        t_node_hash want;
        t_node_hash got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got.key        = m_axis_tdata[63:0];
            got.unique_val = m_axis_tdata[127:64];
            got.depth      = m_axis_tdata[135:128];
            if (expected_hashes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result key=%h unique=%h depth=%0d",
                             got.key, got.unique_val, got.depth);
            end else begin
                want = expected_hashes.pop_front();
                if (got.key != want.key || got.unique_val != want.unique_val ||
                    got.depth != want.depth) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result %0d: expected key=%h unique=%h depth=%0d",
                                 results_seen, want.key, want.unique_val, want.depth);
                        $display("result %0d: got      key=%h unique=%h depth=%0d",
                                 results_seen, got.key, got.unique_val, got.depth);
                    end
                end
            end
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_leaf_nodes();
        test_immediate_values();
        test_child_folding();
        test_stream_quirks();
        test_child_limit();
        test_overlapping_codes();
        test_random_nodes();
        drain_block();
        if (mismatch_count == 0 && expected_hashes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
